// ===== sv/ctw_pkg.sv =====
// ctw_pkg: shared constants, types and address math for the text console writer.
// Used by ctw_cell_ram and text_console_writer; depends on nothing.
package ctw_pkg;

   localparam int SCREEN_ROWS = 25;
   localparam int SCREEN_COLS = 80;
   localparam int CELL_COUNT  = SCREEN_ROWS * SCREEN_COLS;

   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int ROW_W  = $clog2(2 * SCREEN_ROWS);   // cursor row, up to 2*rows-1
   localparam int COL_W  = $clog2(SCREEN_COLS + 1);   // cursor column, up to cols
   localparam int TOP_W  = $clog2(SCREEN_ROWS);       // ring line of screen row 0
   localparam int RING_W = ROW_W + 1;
   localparam int CELL_W = 16;
   localparam int ATTR_W = 8;
   localparam int CHAR_W = 8;

   localparam logic [ROW_W-1:0]  ROW_LIMIT    = ROW_W'(2 * SCREEN_ROWS - 1);
   localparam logic [ROW_W-1:0]  ROW_BOTTOM   = ROW_W'(SCREEN_ROWS - 1);
   localparam logic [COL_W-1:0]  COL_WRAP     = COL_W'(SCREEN_COLS);
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = CHAR_W'(10);
   localparam logic [ATTR_W-1:0] ATTR_RESET   = ATTR_W'(7);

   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [CELL_W-1:0] wdata;
   } ctw_ram_req_type;

   // Cell address of (screen row, column); row must be below SCREEN_ROWS.
   function automatic logic [ADDR_W-1:0] line_addr(logic [TOP_W-1:0] top,
                                                    logic [ROW_W-1:0] row,
                                                    logic [COL_W-1:0] col);
      logic [RING_W-1:0] ring;
      ring = RING_W'(top) + RING_W'(row);
      if (ring >= RING_W'(SCREEN_ROWS)) begin
         ring = ring - RING_W'(SCREEN_ROWS);
      end
      return ADDR_W'(ring) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col);
   endfunction

endpackage

// ===== sv/ctw_cell_ram.sv =====
// ctw_cell_ram: single-port screen cell store, one access per cycle, registered read.
// Depends on ctw_pkg for depth, widths and the request struct.
module ctw_cell_ram (
   input  logic                     clock,
   input  ctw_pkg::ctw_ram_req_type ram_req,
   output logic [ctw_pkg::CELL_W-1:0] rd_data
);

   logic [ctw_pkg::CELL_W-1:0] mem [ctw_pkg::CELL_COUNT];
   logic [ctw_pkg::CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.addr] <= ram_req.wdata;
      end
      rd_data_ff <= mem[ram_req.addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/text_console_writer.sv =====
// text_console_writer: 80x25 text console cell store with cursor and deferred scroll.
// Depends on ctw_pkg and ctw_cell_ram.
//
//  channel | ports                                         | dir | beat
//  --------+-----------------------------------------------+-----+---------------------------
//  req     | req_valid/ready, operation, char_code, row... | in  | one put or one cell read
//  rsp     | rsp_valid/ready, read_data, cursor_*, done    | out | one result per req beat
//  csr     | csr_valid/ready, csr_text_attribute           | in  | attribute byte write
//
// Sequencing: a read waits in ST_READ for the registered RAM data; a newline or a plain
//   put is answered from ST_IDLE. A put that scrolls first zeroes the old top line through
//   the single RAM port once for each pending row (up to 25), then stores the held byte.
// Reset: a clearing pass writes zero to all 2000 cells; req_ready is
//   low meanwhile. csr writes are always taken.
// Stalls: the result sits in an output register; a new req beat is taken while it
//   is being handed off, but not while it is stuck.
module text_console_writer (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_char_code,
   input  logic [4:0]  req_read_row,
   input  logic [6:0]  req_read_col,
   input  logic        req_end_of_write,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_read_data,
   output logic [5:0]  rsp_cursor_row,
   output logic [6:0]  rsp_cursor_col,
   output logic        rsp_write_done,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_text_attribute
);

   // sequencer states
   localparam logic [2:0] ST_CLEAR  = 3'd0;  // reset clearing pass
   localparam logic [2:0] ST_IDLE   = 3'd1;  // take a req beat
   localparam logic [2:0] ST_READ   = 3'd2;  // RAM read data arrives
   localparam logic [2:0] ST_SCROLL = 3'd3;  // zero the old top line
   localparam logic [2:0] ST_WRITE  = 3'd4;  // store the held byte after scrolling

   logic [2:0]                   state_ff, state_in;
   logic [ctw_pkg::ADDR_W-1:0]   sweep_ff, sweep_in;     // clear address / line column
   logic [ctw_pkg::TOP_W-1:0]    top_ff, top_in;
   logic [ctw_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [ctw_pkg::COL_W-1:0]    col_ff, col_in;
   logic [ctw_pkg::ATTR_W-1:0]   attr_ff, attr_in;
   logic [ctw_pkg::CHAR_W-1:0]   code_ff, code_in;       // byte held across a scroll
   logic                         eow_ff, eow_in;
   logic                         rd_zero_ff, rd_zero_in; // read was out of range

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ctw_pkg::CELL_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [ctw_pkg::ROW_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [ctw_pkg::COL_W-1:0]    rsp_col_ff, rsp_col_in;
   logic                         rsp_done_ff, rsp_done_in;

   ctw_pkg::ctw_ram_req_type     ram_req;
   logic [ctw_pkg::CELL_W-1:0]   ram_rdata;

   logic                         accept;
   logic                         is_put;
   logic                         is_newline;
   logic                         wrap;
   logic                         read_in_range;
   logic                         need_scroll;
   logic [ctw_pkg::ROW_W-1:0]    bumped_row;
   logic [ctw_pkg::ROW_W-1:0]    put_row;
   logic [ctw_pkg::COL_W-1:0]    put_col;

   ctw_cell_ram u_cell_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign is_put     = (req_operation == ctw_pkg::OP_PUT);
   assign is_newline = (req_char_code == ctw_pkg::NEWLINE_CODE);
   assign wrap       = (col_ff >= ctw_pkg::COL_WRAP);
   assign bumped_row = (row_ff < ctw_pkg::ROW_LIMIT) ? row_ff + 1'b1 : ctw_pkg::ROW_LIMIT;
   assign put_row    = wrap ? bumped_row : row_ff;
   assign put_col    = wrap ? '0 : col_ff;
   assign need_scroll = (put_row > ctw_pkg::ROW_BOTTOM);
   assign read_in_range = (8'(req_read_row) < 8'(ctw_pkg::SCREEN_ROWS)) &&
                          (8'(req_read_col) < 8'(ctw_pkg::SCREEN_COLS));

   // one RAM access per cycle, chosen by state
   always_comb begin
      ram_req.we    = 1'b0;
      ram_req.addr  = ctw_pkg::line_addr(top_ff, ctw_pkg::ROW_W'(req_read_row),
                                         ctw_pkg::COL_W'(req_read_col));
      ram_req.wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            ram_req.we   = 1'b1;
            ram_req.addr = sweep_ff;
         end
         ST_SCROLL: begin
            // row 0 of the ring is the old top line
            ram_req.we   = 1'b1;
            ram_req.addr = ctw_pkg::line_addr(top_ff, '0, ctw_pkg::COL_W'(sweep_ff));
         end
         ST_WRITE: begin
            ram_req.we    = 1'b1;
            ram_req.addr  = ctw_pkg::line_addr(top_ff, row_ff, col_ff);
            ram_req.wdata = {attr_ff, code_ff};
         end
         ST_IDLE: begin
            if (accept && is_put && !is_newline && !need_scroll) begin
               ram_req.we    = 1'b1;
               ram_req.addr  = ctw_pkg::line_addr(top_ff, put_row, put_col);
               ram_req.wdata = {attr_ff, req_char_code};
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      top_in       = top_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      attr_in      = attr_ff;
      code_in      = code_ff;
      eow_in       = eow_ff;
      rd_zero_in   = rd_zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_done_in  = rsp_done_ff;

      if (csr_valid && csr_ready) begin
         attr_in = csr_text_attribute;
      end

      case (state_ff)
         ST_CLEAR: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == ctw_pkg::ADDR_W'(ctw_pkg::CELL_COUNT - 1)) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (!is_put) begin
                  rd_zero_in = !read_in_range;
                  state_in   = ST_READ;
               end else if (is_newline) begin
                  row_in       = bumped_row;
                  col_in       = '0;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_row_in   = bumped_row;
                  rsp_col_in   = '0;
                  rsp_done_in  = req_end_of_write;
               end else if (!need_scroll) begin
                  row_in       = put_row;
                  col_in       = put_col + 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_row_in   = put_row;
                  rsp_col_in   = put_col + 1'b1;
                  rsp_done_in  = req_end_of_write;
               end else begin
                  row_in   = put_row;
                  col_in   = put_col;
                  code_in  = req_char_code;
                  eow_in   = req_end_of_write;
                  sweep_in = '0;
                  state_in = ST_SCROLL;
               end
            end
         end
         ST_READ: begin
            // output slot was freed when this beat was taken
            rsp_valid_in = 1'b1;
            rsp_data_in  = rd_zero_ff ? '0 : ram_rdata;
            rsp_row_in   = row_ff;
            rsp_col_in   = col_ff;
            rsp_done_in  = 1'b0;
            state_in     = ST_IDLE;
         end
         ST_SCROLL: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == ctw_pkg::ADDR_W'(ctw_pkg::SCREEN_COLS - 1)) begin
               sweep_in = '0;
               top_in   = (top_ff == ctw_pkg::TOP_W'(ctw_pkg::SCREEN_ROWS - 1)) ?
                          '0 : top_ff + 1'b1;
               row_in   = row_ff - 1'b1;
               if (row_ff - 1'b1 == ctw_pkg::ROW_BOTTOM) begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            col_in       = col_ff + 1'b1;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            rsp_row_in   = row_ff;
            rsp_col_in   = col_ff + 1'b1;
            rsp_done_in  = eow_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         top_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         attr_ff      <= ctw_pkg::ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         top_ff       <= top_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      eow_ff      <= eow_in;
      rd_zero_ff  <= rd_zero_in;
      rsp_data_ff <= rsp_data_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_cursor_row = 6'(rsp_row_ff);
   assign rsp_cursor_col = 7'(rsp_col_ff);
   assign rsp_write_done = rsp_done_ff;

endmodule
